@@ sv/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
package tcw_pkg;

  // Opcodes of the input channel
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Character codes
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0a;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_COLOUR_LO = 8'h10;
  localparam logic [7:0] CH_COLOUR_HI = 8'h1f;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_DEL       = 8'h7f;

  localparam logic [7:0] COLOUR_RESET = 8'h0f;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cursor_index;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic        did_scroll;
  } out_item_t;

  // Command classes produced by the front end
  typedef enum logic [3:0] {
    CL_NOP,
    CL_PRINT,
    CL_NEWLINE,
    CL_CR,
    CL_TAB,
    CL_BS,
    CL_COLOUR,
    CL_READ,
    CL_CLEAR
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [7:0]  code;
    logic [10:0] index;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_READ,
    BK_BS_WR,
    BK_SCR_RD,
    BK_SCR_WR,
    BK_SCR_CLR,
    BK_CLEAR,
    BK_DONE
  } bk_state_t;

endpackage

@@ sv/tcw_front.sv @@
// Front end: decodes incoming transactions and queues commands for the back end.
module tcw_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tcw_pkg::in_item_t  in_item,
  output logic               full,
  output logic               cmd_valid,
  output tcw_pkg::cmd_t      cmd,
  input  logic               cmd_pop
);

  tcw_pkg::cmd_t  q_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  tcw_pkg::cls_t  cls;
  logic           push_ok;

  // Classify the item
  always_comb begin
    cls = tcw_pkg::CL_NOP;
    case (in_item.opcode)
      tcw_pkg::OP_PUT: begin
        if (in_item.char_code >= tcw_pkg::CH_SPACE && in_item.char_code < tcw_pkg::CH_DEL) begin
          cls = tcw_pkg::CL_PRINT;
        end else if (in_item.char_code == tcw_pkg::CH_LF) begin
          cls = tcw_pkg::CL_NEWLINE;
        end else if (in_item.char_code == tcw_pkg::CH_CR) begin
          cls = tcw_pkg::CL_CR;
        end else if (in_item.char_code == tcw_pkg::CH_TAB) begin
          cls = tcw_pkg::CL_TAB;
        end else if (in_item.char_code == tcw_pkg::CH_BS) begin
          cls = tcw_pkg::CL_BS;
        end else if (in_item.char_code >= tcw_pkg::CH_COLOUR_LO &&
                     in_item.char_code <= tcw_pkg::CH_COLOUR_HI) begin
          cls = tcw_pkg::CL_COLOUR;
        end
      end
      tcw_pkg::OP_READ:  cls = tcw_pkg::CL_READ;
      tcw_pkg::OP_CLEAR: cls = tcw_pkg::CL_CLEAR;
      default:           cls = tcw_pkg::CL_NOP;
    endcase
  end

  // Two-entry command queue
  assign full      = (cnt_r == 2'd2);
  assign push_ok   = push && !full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push_ok) begin
      wp_nxt = ~wp_r;
    end
    if (cmd_pop && cmd_valid) begin
      rp_nxt = ~rp_r;
    end
    case ({push_ok, cmd_pop && cmd_valid})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= '{cls: cls, code: in_item.char_code, index: in_item.cell_index};
    end
  end

endmodule

@@ sv/tcw_back.sv @@
// Back end: cursor state, screen store, scroll and clear sweeps, result queue.
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  tcw_pkg::cmd_t       cmd,
  output logic                cmd_pop,
  input  logic [4:0]          first_row,
  output tcw_pkg::out_item_t  out_item,
  output logic                empty,
  input  logic                pop
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

  tcw_pkg::bk_state_t state_r, state_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [7:0]    colour_r, colour_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [7:0]    res_char_r, res_char_nxt;
  logic [7:0]    res_attr_r, res_attr_nxt;
  logic          res_scroll_r, res_scroll_nxt;
  logic [AW-1:0] base_r;
  logic [4:0]    top_row;

  // Screen store
  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [15:0]   mem_wd;

  // Result queue
  tcw_pkg::out_item_t oq_r [2];
  logic          owp_r, owp_nxt;
  logic          orp_r, orp_nxt;
  logic [1:0]    ocnt_r, ocnt_nxt;
  logic          out_full, out_push, out_pop;

  // Cursor move helpers
  logic [CW:0]   tab_col;
  logic [CW-1:0] col_new;
  logic [AW:0]   pos_new;
  logic          adv_row;
  logic          scroll_start;
  logic          in_range;

  assign in_range     = (32'(cmd.index) < CELLS);
  assign scroll_start = adv_row && (row_r == LAST_ROW);
  assign tab_col      = ({1'b0, col_r} & ~(CW + 1)'(7)) + (CW + 1)'(8);

  // Scroll window base, from the clamped first scrolled row
  assign top_row = ({1'b0, first_row} > 6'(ROWS - 1)) ? 5'(ROWS - 1) : first_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else begin
      base_r <= AW'(32'(top_row) * COLUMNS);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcw_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          case (cmd.cls)
            tcw_pkg::CL_READ:  state_nxt = in_range ? tcw_pkg::BK_READ : tcw_pkg::BK_DONE;
            tcw_pkg::CL_BS:    state_nxt = (col_r != '0) ? tcw_pkg::BK_BS_WR : tcw_pkg::BK_DONE;
            tcw_pkg::CL_CLEAR: state_nxt = tcw_pkg::BK_CLEAR;
            default: begin
              if (scroll_start) begin
                state_nxt = (base_r == LAST_BASE) ? tcw_pkg::BK_SCR_CLR : tcw_pkg::BK_SCR_RD;
              end else begin
                state_nxt = tcw_pkg::BK_DONE;
              end
            end
          endcase
        end
      end
      tcw_pkg::BK_READ:   state_nxt = tcw_pkg::BK_DONE;
      tcw_pkg::BK_BS_WR:  state_nxt = tcw_pkg::BK_DONE;
      tcw_pkg::BK_SCR_RD: state_nxt = tcw_pkg::BK_SCR_WR;
      tcw_pkg::BK_SCR_WR: begin
        state_nxt = (ptr_r + AW'(1) == LAST_BASE) ? tcw_pkg::BK_SCR_CLR : tcw_pkg::BK_SCR_RD;
      end
      tcw_pkg::BK_SCR_CLR: begin
        if (ptr_r == LAST_CELL) begin
          state_nxt = tcw_pkg::BK_DONE;
        end
      end
      tcw_pkg::BK_CLEAR: begin
        if (ptr_r == LAST_CELL) begin
          state_nxt = tcw_pkg::BK_DONE;
        end
      end
      tcw_pkg::BK_DONE: begin
        if (!out_full) begin
          state_nxt = tcw_pkg::BK_IDLE;
        end
      end
      default: state_nxt = tcw_pkg::BK_IDLE;
    endcase
  end

  // Datapath and store controls
  always_comb begin
    col_nxt        = col_r;
    row_nxt        = row_r;
    pos_nxt        = pos_r;
    colour_nxt     = colour_r;
    ptr_nxt        = ptr_r;
    res_char_nxt   = res_char_r;
    res_attr_nxt   = res_attr_r;
    res_scroll_nxt = res_scroll_r;
    mem_we         = 1'b0;
    mem_wa         = pos_r;
    mem_wd         = '0;
    mem_re         = 1'b0;
    mem_ra         = pos_r;
    cmd_pop        = 1'b0;
    out_push       = 1'b0;
    adv_row        = 1'b0;
    col_new        = col_r;
    pos_new        = {1'b0, pos_r};
    case (state_r)
      tcw_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop        = 1'b1;
          res_char_nxt   = '0;
          res_attr_nxt   = '0;
          res_scroll_nxt = 1'b0;
          case (cmd.cls)
            tcw_pkg::CL_PRINT: begin
              mem_we  = 1'b1;
              mem_wd  = {colour_r, cmd.code};
              pos_new = {1'b0, pos_r} + (AW + 1)'(1);
              if (col_r == LAST_COL) begin
                col_new = '0;
                adv_row = 1'b1;
              end else begin
                col_new = col_r + CW'(1);
              end
            end
            tcw_pkg::CL_NEWLINE: begin
              col_new = '0;
              adv_row = 1'b1;
              pos_new = {1'b0, pos_r} - (AW + 1)'(col_r) + (AW + 1)'(COLUMNS);
            end
            tcw_pkg::CL_CR: begin
              col_new = '0;
              pos_new = {1'b0, pos_r} - (AW + 1)'(col_r);
            end
            tcw_pkg::CL_TAB: begin
              if (tab_col >= (CW + 1)'(COLUMNS)) begin
                col_new = '0;
                adv_row = 1'b1;
                pos_new = {1'b0, pos_r} - (AW + 1)'(col_r) + (AW + 1)'(COLUMNS);
              end else begin
                col_new = CW'(tab_col);
                pos_new = {1'b0, pos_r} + (AW + 1)'(tab_col - {1'b0, col_r});
              end
            end
            tcw_pkg::CL_BS: begin
              if (col_r != '0) begin
                col_new = col_r - CW'(1);
                pos_new = {1'b0, pos_r} - (AW + 1)'(1);
                mem_re  = 1'b1;
                mem_ra  = pos_r - AW'(1);
              end
            end
            tcw_pkg::CL_COLOUR: begin
              colour_nxt = {4'h0, cmd.code[3:0]};
            end
            tcw_pkg::CL_READ: begin
              if (in_range) begin
                mem_re = 1'b1;
                mem_ra = AW'(cmd.index);
              end
            end
            tcw_pkg::CL_CLEAR: begin
              col_new = '0;
              pos_new = '0;
              row_nxt = '0;
              ptr_nxt = '0;
            end
            default: ;
          endcase
          // Cursor update, with scroll when the last row is passed
          if (adv_row && (row_r == LAST_ROW)) begin
            col_nxt        = '0;
            pos_nxt        = LAST_BASE;
            ptr_nxt        = base_r;
            res_scroll_nxt = 1'b1;
          end else begin
            col_nxt = col_new;
            pos_nxt = AW'(pos_new);
            if (adv_row) begin
              row_nxt = row_r + RW'(1);
            end
          end
        end
      end
      tcw_pkg::BK_READ: begin
        res_char_nxt = rdata_r[7:0];
        res_attr_nxt = rdata_r[15:8];
      end
      tcw_pkg::BK_BS_WR: begin
        mem_we = 1'b1;
        mem_wd = {rdata_r[15:8], tcw_pkg::CH_SPACE};
      end
      tcw_pkg::BK_SCR_RD: begin
        mem_re = 1'b1;
        mem_ra = ptr_r + AW'(COLUMNS);
      end
      tcw_pkg::BK_SCR_WR: begin
        mem_we  = 1'b1;
        mem_wa  = ptr_r;
        mem_wd  = rdata_r;
        ptr_nxt = ptr_r + AW'(1);
      end
      tcw_pkg::BK_SCR_CLR, tcw_pkg::BK_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = ptr_r;
        ptr_nxt = ptr_r + AW'(1);
      end
      tcw_pkg::BK_DONE: begin
        out_push = !out_full;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tcw_pkg::BK_IDLE;
      col_r      <= '0;
      row_r      <= '0;
      pos_r      <= '0;
      colour_r   <= tcw_pkg::COLOUR_RESET;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      pos_r      <= pos_nxt;
      colour_r   <= colour_nxt;
    end
  end

  // Sweep pointer and result fields
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    res_char_r   <= res_char_nxt;
    res_attr_r   <= res_attr_nxt;
    res_scroll_r <= res_scroll_nxt;
  end

  // Store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  // Two-entry result queue
  assign out_full = (ocnt_r == 2'd2);
  assign empty    = (ocnt_r == 2'd0);
  assign out_pop  = pop && !empty;
  assign out_item = oq_r[orp_r];

  always_comb begin
    owp_nxt  = out_push ? ~owp_r : owp_r;
    orp_nxt  = out_pop ? ~orp_r : orp_r;
    case ({out_push, out_pop})
      2'b10:   ocnt_nxt = ocnt_r + 2'd1;
      2'b01:   ocnt_nxt = ocnt_r - 2'd1;
      default: ocnt_nxt = ocnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      owp_r  <= owp_nxt;
      orp_r  <= orp_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      oq_r[owp_r] <= '{cursor_index: 11'(pos_r), cell_char: res_char_r,
                       cell_attr: res_attr_r, did_scroll: res_scroll_r};
    end
  end

  // Linear cursor position tracks row and column
  a_pos_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) == 32'(row_r) * COLUMNS + 32'(col_r))
    else $error("cursor position out of step with row and column");

  // Commands are taken only by the idle sequencer
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == tcw_pkg::BK_IDLE))
    else $error("command taken while busy");

  // A scrolled result leaves the cursor at the start of the last row
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::BK_DONE && res_scroll_r) |-> (row_r == LAST_ROW && col_r == '0))
    else $error("cursor not on last row after scroll");

  // The clear sweep runs with the cursor at home
  a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::BK_CLEAR) |-> (pos_r == '0))
    else $error("cursor not home during clear");

endmodule

@@ sv/text_console_writer.sv @@
// Top level of the text console writer: configuration register, front and back ends.
//
// Usage:
//   Input queue: drive in_item and raise push; the transaction is taken at an
//   edge with push high and full low. Opcode 0 puts a character, 1 reads a
//   cell, 2 clears the screen and homes the cursor.
//   Result queue: one result per input transaction, in order. It is on
//   out_item while empty is low and leaves at an edge with pop high.
//   cfg_we/cfg_wdata write the first scrolled row; write only while idle.
// Sequencing:
//   Simple put-character transactions pass through the back end's idle and done
//   states; the back end takes the next command only once the last result is
//   queued. In-range reads and backspaces away from column 0 pass through one
//   more state, since the store's read port is registered. A scroll moves the
//   cells below the first scrolled row up one row, reading and writing moved cells
//   in alternate states, then clears the last row one cell per cycle. A clear writes every cell once.
// Reset: cursor at home, colour 0x0f, queues empty; screen contents are not
//   cleared and read back undefined until written or cleared.
// Back pressure: when pop stays low the result queue fills, the back end
//   holds, the two-entry command queue fills and full rises.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tcw_pkg::in_item_t   in_item,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output tcw_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata
);

  logic [4:0]     first_row_r, first_row_nxt;
  logic           cmd_valid;
  logic           cmd_pop;
  tcw_pkg::cmd_t  cmd;

  // First scrolled row register
  assign first_row_nxt = cfg_we ? cfg_wdata : first_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_row_r <= 5'd0;
    end else begin
      first_row_r <= first_row_nxt;
    end
  end

  tcw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .first_row (first_row_r),
    .out_item  (out_item),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
